// ===== rtl/core/twrr_pkg.sv =====
// Shared constants for the rolling time-window reducer.
`timescale 1ns / 1ps
package twrr_pkg;
	localparam int DEF_WINDOW_DEPTH = 256;
	localparam int DEF_SAMPLE_WIDTH = 24;
	localparam int TIME_W           = 48;
	localparam int MODE_W           = 2;
	localparam int CFG_IDX_W        = 8;

	localparam logic [TIME_W-1:0] WINDOW_RESET = 48'd1000000;

	localparam logic [MODE_W-1:0] MODE_MEAN = 2'd0;
	localparam logic [MODE_W-1:0] MODE_RMS  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_MIN  = 2'd2;
	localparam logic [MODE_W-1:0] MODE_MAX  = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MODE   = 8'd1;
endpackage

// ===== rtl/core/time_window_rolling_reduce.sv =====
// Top level: rolling time-window mean / RMS / min / max over a ring of samples.
`timescale 1ns / 1ps
// Usage:
//   s_* stream: one word per sample; s_tdata = timestamp_ns, sample_value;
//   s_tuser = first_of_record, which empties the window first.
//   m_* stream: one word per sample; m_tdata = reduced_value, window_count;
//   m_tuser = window_truncated (a held in-window sample was evicted).
//   cfg_* port: index 0 window_ns, index 1 reduce_mode; always ready, write
//   only while idle.
// One sample at a time. Per sample: an accept step, then a walk that
//   drops aged-out samples until an age check ends it (no check when the
//   window is empty), a store step, a scan through the value memory, then
//   for mean and RMS a bit-serial divider, for RMS also a bit-serial square
//   root, and a step to the output register.
// The result sits in an output register: the next sample is taken while it
//   waits; a stalled receiver holds the block at its final step only.
// Reset empties the window and restores window_ns = 1000000, mode mean;
//   memory contents need no clearing.
module time_window_rolling_reduce #(
	parameter int WINDOW_DEPTH = twrr_pkg::DEF_WINDOW_DEPTH,
	parameter int SAMPLE_WIDTH = twrr_pkg::DEF_SAMPLE_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [((twrr_pkg::TIME_W + SAMPLE_WIDTH + 7) / 8) * 8 - 1:0]
	                                      s_tdata,   // timestamp_ns, sample_value, zero pad
	input  logic                          s_tuser,   // first_of_record
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [((SAMPLE_WIDTH + $clog2(WINDOW_DEPTH + 1) + 7) / 8) * 8 - 1:0]
	                                      m_tdata,   // reduced_value, window_count, zero pad
	output logic                          m_tuser,   // window_truncated
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [twrr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [twrr_pkg::TIME_W-1:0]   cfg_data
);
	localparam int TW   = twrr_pkg::TIME_W;
	localparam int SW   = SAMPLE_WIDTH;
	localparam int PW   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int CW   = $clog2(WINDOW_DEPTH + 1);
	localparam int IDW  = ((TW + SW + 7) / 8) * 8;
	localparam int ODW  = ((SW + CW + 7) / 8) * 8;
	localparam int SUMW = SW + CW;
	localparam int DDW  = 2 * SW + CW;
	localparam int RW   = 2 * SW;
	localparam int STW  = $clog2(DDW + 1);

	localparam logic [PW-1:0] PTR_LAST = PW'(WINDOW_DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(WINDOW_DEPTH);
	localparam logic [SW-1:0] VAL_MAX  = {1'b0, {(SW-1){1'b1}}};
	localparam logic [RW-1:0] BIT_INIT = RW'(1) << (RW - 2);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DRD  = 3'd1;
	localparam logic [2:0] ST_DCK  = 3'd2;
	localparam logic [2:0] ST_STOR = 3'd3;
	localparam logic [2:0] ST_SCAN = 3'd4;
	localparam logic [2:0] ST_DIV  = 3'd5;
	localparam logic [2:0] ST_SQRT = 3'd6;
	localparam logic [2:0] ST_DONE = 3'd7;

	function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
		return (p == PTR_LAST) ? '0 : p + PW'(1);
	endfunction

	logic [2:0]                 state_q;
	logic [TW-1:0]              window_q;
	logic [twrr_pkg::MODE_W-1:0] mode_q;
	logic [PW-1:0]              oldest_q, newest_q, rp_q;
	logic [CW-1:0]              count_q, iss_q;
	logic [TW-1:0]              t_q;
	logic signed [SW-1:0]       v_q;
	logic                       trunc_q;
	logic                       rd_s1, vld_s2, init_q;
	logic signed [SW-1:0]       v_s2;
	logic [RW-1:0]              sq_s2;
	logic signed [SUMW-1:0]     sum_q;
	logic [DDW-1:0]             sumsq_q;
	logic signed [SW-1:0]       lo_q, hi_q;
	logic [DDW-1:0]             dd_q;
	logic [CW-1:0]              rem_q;
	logic [STW-1:0]             step_q;
	logic [RW-1:0]              n_q, root_q, bit_q;
	logic signed [SW-1:0]       res_q;
	logic                       m_tvalid_q;
	logic [SW-1:0]              out_val_q;
	logic [CW-1:0]              out_cnt_q;
	logic                       out_trunc_q;

	logic [TW-1:0]              t_rdata;
	logic [SW-1:0]              v_rdata;
	logic                       we;
	logic [CW:0]                trial;
	logic [RW-1:0]              rb;
	logic [SUMW-1:0]            sum_mag;

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = ODW'({out_cnt_q, out_val_q});
	assign m_tuser   = out_trunc_q;
	assign we        = (state_q == ST_STOR);
	assign trial     = {rem_q, dd_q[DDW-1]};
	assign rb        = root_q + bit_q;
	assign sum_mag   = sum_q[SUMW-1] ? SUMW'(-sum_q) : SUMW'(sum_q);

	twrr_ram #(.DATA_W(TW), .DEPTH(WINDOW_DEPTH)) u_time_ram (
		.clk(clk), .we(we), .waddr(newest_q), .wdata(t_q),
		.raddr(oldest_q), .rdata(t_rdata)
	);

	twrr_ram #(.DATA_W(SW), .DEPTH(WINDOW_DEPTH)) u_value_ram (
		.clk(clk), .we(we), .waddr(newest_q), .wdata(v_q),
		.raddr(rp_q), .rdata(v_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= twrr_pkg::WINDOW_RESET;
			mode_q   <= twrr_pkg::MODE_MEAN;
		end else if (cfg_valid) begin
			if (cfg_index == twrr_pkg::REG_WINDOW) begin
				window_q <= cfg_data;
			end else if (cfg_index == twrr_pkg::REG_MODE) begin
				mode_q <= cfg_data[twrr_pkg::MODE_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_s1  <= (state_q == ST_SCAN) && (iss_q != count_q);
		vld_s2 <= rd_s1;
		v_s2   <= $signed(v_rdata);
		sq_s2  <= RW'(RW'($signed(v_rdata)) * RW'($signed(v_rdata)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			oldest_q   <= '0;
			newest_q   <= '0;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						t_q     <= s_tdata[TW-1:0];
						v_q     <= $signed(s_tdata[TW+SW-1:TW]);
						trunc_q <= 1'b0;
						if (s_tuser) begin
							count_q  <= '0;
							oldest_q <= newest_q;
						end
						state_q <= ST_DRD;
					end
				end
				ST_DRD: begin
					state_q <= (count_q == '0) ? ST_STOR : ST_DCK;
				end
				ST_DCK: begin
					if (t_q >= t_rdata && (t_q - t_rdata) > window_q) begin
						oldest_q <= nxt(oldest_q);
						count_q  <= count_q - CW'(1);
						state_q  <= ST_DRD;
					end else begin
						state_q <= ST_STOR;
					end
				end
				ST_STOR: begin
					if (count_q == CNT_FULL) begin
						oldest_q <= nxt(oldest_q);
						rp_q     <= nxt(oldest_q);
						trunc_q  <= 1'b1;
					end else begin
						count_q <= count_q + CW'(1);
						rp_q    <= oldest_q;
					end
					newest_q <= nxt(newest_q);
					iss_q    <= '0;
					sum_q    <= '0;
					sumsq_q  <= '0;
					init_q   <= 1'b1;
					state_q  <= ST_SCAN;
				end
				ST_SCAN: begin
					if (iss_q != count_q) begin
						iss_q <= iss_q + CW'(1);
						rp_q  <= nxt(rp_q);
					end
					if (vld_s2) begin
						sum_q   <= sum_q + SUMW'(v_s2);
						sumsq_q <= sumsq_q + DDW'(sq_s2);
						init_q  <= 1'b0;
						if (init_q || v_s2 < lo_q) lo_q <= v_s2;
						if (init_q || v_s2 > hi_q) hi_q <= v_s2;
					end
					if (iss_q == count_q && !rd_s1 && !vld_s2) begin
						rem_q  <= '0;
						step_q <= '0;
						if (mode_q == twrr_pkg::MODE_MIN) begin
							res_q   <= lo_q;
							state_q <= ST_DONE;
						end else if (mode_q == twrr_pkg::MODE_MAX) begin
							res_q   <= hi_q;
							state_q <= ST_DONE;
						end else begin
							dd_q    <= (mode_q == twrr_pkg::MODE_MEAN) ?
								DDW'(sum_mag) : sumsq_q;
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (step_q == STW'(DDW)) begin
						step_q <= '0;
						if (mode_q == twrr_pkg::MODE_MEAN) begin
							res_q   <= sum_q[SUMW-1] ? -$signed(dd_q[SW-1:0])
								: $signed(dd_q[SW-1:0]);
							state_q <= ST_DONE;
						end else begin
							n_q     <= dd_q[RW-1:0];
							root_q  <= '0;
							bit_q   <= BIT_INIT;
							state_q <= ST_SQRT;
						end
					end else begin
						step_q <= step_q + STW'(1);
						if (trial >= {1'b0, count_q}) begin
							rem_q <= CW'(trial - {1'b0, count_q});
							dd_q  <= {dd_q[DDW-2:0], 1'b1};
						end else begin
							rem_q <= trial[CW-1:0];
							dd_q  <= {dd_q[DDW-2:0], 1'b0};
						end
					end
				end
				ST_SQRT: begin
					if (step_q == STW'(SW)) begin
						res_q   <= (root_q > RW'(VAL_MAX)) ? $signed(VAL_MAX)
							: $signed(root_q[SW-1:0]);
						state_q <= ST_DONE;
					end else begin
						step_q <= step_q + STW'(1);
						bit_q  <= bit_q >> 2;
						if (n_q >= rb) begin
							n_q    <= n_q - rb;
							root_q <= (root_q >> 1) + bit_q;
						end else begin
							root_q <= root_q >> 1;
						end
					end
				end
				ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						out_val_q   <= res_q;
						out_cnt_q   <= count_q;
						out_trunc_q <= trunc_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("held count above depth");
	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> count_q != '0)
		else $error("scan over empty window");
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == ST_DONE))
		else $error("result loaded outside final step");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE && count_q != CNT_FULL && count_q != '0
		|-> nxt(PW'(oldest_q + PW'(count_q - CW'(1)))) == newest_q
			|| WINDOW_DEPTH != (1 << PW))
		else $error("ring pointers disagree with count");
`endif
endmodule

// ===== rtl/core/twrr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module twrr_ram #(
	parameter int DATA_W = 24,
	parameter int DEPTH  = 256
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [DATA_W-1:0]                     wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [DATA_W-1:0]                     rdata
);
	logic [DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== tb/time_window_rolling_reduce_test.sv =====
// Testbench for the rolling time-window reducer: randomised stream stimulus, scoreboard check.
`timescale 1ns / 1ps
module time_window_rolling_reduce_test;
	localparam int DEPTH = 256;
	localparam int IN_W  = 72;
	localparam int OUT_W = 40;
	localparam int HOLD  = 400;
	localparam int WDOG  = 20000;

	typedef struct packed {
		logic [47:0] stamp;
		logic [23:0] value;
		logic        first;
	} sample_t;

	typedef struct packed {
		logic [23:0] reduced;
		logic [8:0]  count;
		logic        trunc;
	} summary_t;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata;  // timestamp_ns, sample_value, zero pad
	logic              s_tuser;  // first_of_record
	logic              m_tvalid;
	logic              m_tready;
	logic [OUT_W-1:0]  m_tdata;  // reduced_value, window_count, zero pad
	logic              m_tuser;  // window_truncated
	logic              cfg_valid;
	logic              cfg_ready;
	logic [twrr_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [twrr_pkg::TIME_W-1:0] cfg_data;

	time_window_rolling_reduce dut (.*);

	sample_t  pending_samples[$];
	summary_t expected_summaries[$];

	// predictor state
	logic signed [23:0] val_store [DEPTH];
	logic [47:0]        stamp_store [DEPTH];
	int                 oldest_slot, newest_slot, held;
	logic [47:0]        win_len;
	logic [1:0]         mode;

	int  errors;
	int  idle_cycles;
	int  gap_left;
	int  hold_left;
	bit  long_hold_req;
	bit  s_acc;
	logic [47:0] t_now;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= root + bitv) begin
				n -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	function automatic summary_t window_reduce_step(sample_t s);
		summary_t res;
		longint sum, lo, hi, v;
		longint unsigned sumsq, r;
		int p;
		res.trunc = 0;
		if (s.first) begin
			held = 0;
			oldest_slot = newest_slot;
		end
		while (held > 0) begin
			if (s.stamp >= stamp_store[oldest_slot] &&
			    s.stamp - stamp_store[oldest_slot] > win_len) begin
				oldest_slot = (oldest_slot + 1) % DEPTH;
				held--;
			end else begin
				break;
			end
		end
		if (held >= DEPTH) begin
			oldest_slot = (oldest_slot + 1) % DEPTH;
			held--;
			res.trunc = 1;
		end
		val_store[newest_slot] = s.value;
		stamp_store[newest_slot] = s.stamp;
		newest_slot = (newest_slot + 1) % DEPTH;
		held++;
		sum = 0;
		sumsq = 0;
		p = oldest_slot;
		lo = val_store[p];
		hi = lo;
		for (int k = 0; k < held; k++) begin
			v = val_store[p];
			sum += v;
			sumsq += longint'(v * v);
			if (v < lo) lo = v;
			if (v > hi) hi = v;
			p = (p + 1) % DEPTH;
		end
		case (mode)
			twrr_pkg::MODE_MEAN: res.reduced = 24'(sum / held);
			twrr_pkg::MODE_RMS: begin
				r = int_sqrt(sumsq / longint'(held));
				res.reduced = (r > 64'd8388607) ? 24'h7FFFFF : 24'(r);
			end
			twrr_pkg::MODE_MIN: res.reduced = 24'(lo);
			default: res.reduced = 24'(hi);
		endcase
		res.count = 9'(held);
		return res;
	endfunction

	function automatic int pick_gap();
		int d;
		d = $urandom_range(0, 99);
		if (d < 55) return 0;
		if (d < 95) return $urandom_range(1, 3);
		return $urandom_range(20, 60);
	endfunction

	// driver
	always @(negedge clk or negedge arst_n) begin
		sample_t nxt;
		logic    v_next;
		if (!arst_n) begin
			s_tvalid <= 0;
			s_tdata <= '0;
			s_tuser <= 0;
			gap_left = 0;
		end else if (!s_tvalid || s_acc) begin
			v_next = 0;
			if (s_tvalid) gap_left = pick_gap();
			if (gap_left > 0) begin
				gap_left--;
			end else if (pending_samples.size() > 0) begin
				nxt = pending_samples.pop_front();
				s_tdata <= {nxt.value, nxt.stamp};
				s_tuser <= nxt.first;
				v_next = 1;
			end
			s_tvalid <= v_next;
		end
	end

	// receiver readiness
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 0;
			hold_left = 0;
		end else begin
			if (long_hold_req) begin
				long_hold_req = 0;
				hold_left = 1500;
			end
			if (hold_left == 0 && $urandom_range(0, 99) < 20) hold_left = pick_gap();
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 0;
			end else begin
				m_tready <= 1;
			end
		end
	end

	// monitor, predictor and watchdog
	always @(posedge clk) begin
		summary_t got, want;
		s_acc = s_tvalid && s_tready;
		if (arst_n) begin
			idle_cycles++;
			if (s_tvalid && s_tready) begin
				idle_cycles = 0;
				expected_summaries.insert(expected_summaries.size(), window_reduce_step(
					'{stamp: s_tdata[47:0], value: s_tdata[71:48], first: s_tuser}));
			end
			if (m_tvalid && m_tready) begin
				idle_cycles = 0;
				got = '{reduced: m_tdata[23:0], count: m_tdata[32:24], trunc: m_tuser};
				if (expected_summaries.size() == 0) begin
					errors++;
					$display("%0t: unexpected word %h", $time, got);
				end else begin
					want = expected_summaries.pop_front();
					if (got.reduced !== want.reduced) begin
						errors++;
						$display("%0t: reduced_value exp %0d got %0d", $time,
							$signed(want.reduced), $signed(got.reduced));
					end
					if (got.count !== want.count) begin
						errors++;
						$display("%0t: window_count exp %0d got %0d", $time,
							want.count, got.count);
					end
					if (got.trunc !== want.trunc) begin
						errors++;
						$display("%0t: window_truncated exp %0d got %0d", $time,
							want.trunc, got.trunc);
					end
				end
			end
			if (idle_cycles >= WDOG) begin
				$display("time_window_rolling_reduce test failed");
				$finish;
			end
		end
	end

	task automatic reg_write(logic [twrr_pkg::CFG_IDX_W-1:0] idx, logic [47:0] data);
		@(negedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == twrr_pkg::REG_WINDOW) win_len = data;
		else if (idx == twrr_pkg::REG_MODE) mode = data[1:0];
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	task automatic drain();
		wait (pending_samples.size() == 0 && !s_tvalid && expected_summaries.size() == 0);
		repeat (HOLD) @(posedge clk);
	endtask

	task automatic push_sample(logic [47:0] stamp, logic [23:0] value, logic first);
		pending_samples.insert(pending_samples.size(),
			'{stamp: stamp, value: value, first: first});
	endtask

	function automatic logic [23:0] rand_value();
		int d;
		d = $urandom_range(0, 99);
		if (d < 5) return 24'h800000;
		if (d < 10) return 24'h7FFFFF;
		if (d < 40) return 24'($urandom_range(0, 400)) - 24'd200;
		return 24'($urandom);
	endfunction

	task automatic random_run(int n, int step_max);
		logic first;
		int d;
		for (int i = 0; i < n; i++) begin
			d = $urandom_range(0, 99);
			first = (i == 0) || (d < 3);
			if (first) t_now = {16'($urandom), 32'($urandom)} >> $urandom_range(0, 8);
			else if (d < 6) t_now = t_now - 48'($urandom_range(1, step_max + 1));
			else t_now = t_now + 48'($urandom_range(0, step_max));
			push_sample(t_now, rand_value(), first);
		end
	endtask

	initial begin
		arst_n = 0;
		cfg_valid = 0;
		cfg_index = '0;
		cfg_data = '0;
		errors = 0;
		idle_cycles = 0;
		long_hold_req = 0;
		s_acc = 0;
		oldest_slot = 0;
		newest_slot = 0;
		held = 0;
		win_len = twrr_pkg::WINDOW_RESET;
		mode = twrr_pkg::MODE_MEAN;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: reset config, extremes
		push_sample(48'd0, 24'h7FFFFF, 1);
		push_sample(48'd10, 24'h800000, 0);
		push_sample(48'd20, 24'h800000, 0);
		push_sample(48'hFFFF_FFFF_FFFF, 24'h000001, 1);
		push_sample(48'hFFFF_FFFF_FFF0, 24'hFFFFFF, 0);
		push_sample(48'hFFFF_FFFF_FFFF, 24'h555555, 0);
		drain();
		// RMS saturation with most-negative samples, then one most-positive
		reg_write(twrr_pkg::REG_MODE, 48'(twrr_pkg::MODE_RMS));
		push_sample(48'd100, 24'h800000, 1);
		push_sample(48'd101, 24'h800000, 0);
		push_sample(48'd102, 24'h800000, 0);
		push_sample(48'd103, 24'h7FFFFF, 0);
		drain();
		// zero window, equal stamps; upper data bits of mode ignored
		reg_write(twrr_pkg::REG_WINDOW, 48'd0);
		reg_write(twrr_pkg::REG_MODE, 48'hFFFF_FFFF_FFF2);
		reg_write(8'd2, 48'd5);
		reg_write(8'hFF, 48'hFFFF_FFFF_FFFF);
		push_sample(48'd500, 24'd7, 1);
		push_sample(48'd500, 24'd3, 0);
		push_sample(48'd501, 24'd9, 0);
		push_sample(48'd499, 24'd1, 0);
		push_sample(48'd501, 24'h800000, 0);
		drain();
		reg_write(twrr_pkg::REG_MODE, 48'(twrr_pkg::MODE_MAX));
		push_sample(48'd10, 24'h800000, 1);
		push_sample(48'd10, 24'h800001, 0);
		push_sample(48'd10, 24'h7FFFFE, 0);
		drain();

		reg_write(twrr_pkg::REG_WINDOW, 48'd1);
		random_run(150, 2);
		drain();
		reg_write(twrr_pkg::REG_WINDOW, 48'd0);
		reg_write(twrr_pkg::REG_MODE, 48'(twrr_pkg::MODE_MIN));
		random_run(150, 1);
		drain();
		reg_write(twrr_pkg::REG_WINDOW, 48'hFFFF_FFFF_FFFF);
		reg_write(twrr_pkg::REG_MODE, 48'(twrr_pkg::MODE_MEAN));
		random_run(400, 1000);
		drain();
		reg_write(twrr_pkg::REG_WINDOW, 48'd5000);
		reg_write(twrr_pkg::REG_MODE, 48'(twrr_pkg::MODE_RMS));
		long_hold_req = 1;
		random_run(300, 200);
		drain();
		reg_write(twrr_pkg::REG_WINDOW, 48'd100000);
		reg_write(twrr_pkg::REG_MODE, 48'(twrr_pkg::MODE_MEAN));
		random_run(300, 2000);
		drain();
		reg_write(twrr_pkg::REG_WINDOW, 48'hFFFF_FFFF_FFFF);
		reg_write(twrr_pkg::REG_MODE, 48'(twrr_pkg::MODE_RMS));
		random_run(300, 10);
		drain();
		reg_write(twrr_pkg::REG_WINDOW, 48'd20);
		reg_write(twrr_pkg::REG_MODE, 48'(twrr_pkg::MODE_MAX));
		random_run(150, 5);
		drain();

		if (errors == 0) begin
			$display("time_window_rolling_reduce test passed");
		end else begin
			$display("time_window_rolling_reduce test failed");
		end
		$finish;
	end
endmodule

// ===== filelist.f =====
rtl/core/twrr_pkg.sv
rtl/core/twrr_ram.sv
rtl/core/time_window_rolling_reduce.sv
tb/time_window_rolling_reduce_test.sv
